/* design/hkv_pkg.sv */
// hkv_pkg: shared codes, command type and defaults of the half precision KV cache.
// No dependencies.
`timescale 1ns / 1ps
package hkv_pkg;

  localparam int DEF_MAX_LAYERS    = 4;
  localparam int DEF_MAX_POSITIONS = 256;
  localparam int DEF_MAX_ELEMENTS  = 64;

  localparam logic [2:0] KIND_WRITE    = 3'd0;
  localparam logic [2:0] KIND_READ     = 3'd1;
  localparam logic [2:0] KIND_SHIFT    = 3'd2;
  localparam logic [2:0] KIND_TRUNCATE = 3'd3;
  localparam logic [2:0] KIND_RESET    = 3'd4;

  localparam logic [1:0] REG_LAYERS    = 2'd0;
  localparam logic [1:0] REG_POSITIONS = 2'd1;
  localparam logic [1:0] REG_ELEMENTS  = 2'd2;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_READ,
    OP_REJECT,
    OP_SHIFT,
    OP_TRUNC,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [1:0]  layer;
    logic [7:0]  position;
    logic [5:0]  element;
    logic [15:0] key_half;
    logic [15:0] value_half;
    logic [8:0]  amount;
  } cmd_t;

endpackage

/* design/half_precision_kv_cache.sv */
// Half precision KV cache; depends on hkv_pkg, hkv_front/queue/back. Results are
// registered, a read's also in the memory read register; writes and rejected items
// sustain one transfer per cycle while out_stall is low, a read holds the back end in S_RD.
// Nonzero shift, truncate below the fill and reset walk every entry, as does the clearing
// pass after reset, which holds in_stall high; configuration writes are taken throughout.
`timescale 1ns / 1ps
module half_precision_kv_cache #(
  parameter int MAX_LAYERS    = hkv_pkg::DEF_MAX_LAYERS,
  parameter int MAX_POSITIONS = hkv_pkg::DEF_MAX_POSITIONS,
  parameter int MAX_ELEMENTS  = hkv_pkg::DEF_MAX_ELEMENTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [1:0]  in_layer,
  input  logic [7:0]  in_position,
  input  logic [5:0]  in_element,
  input  logic [31:0] in_key_bits,
  input  logic [31:0] in_value_bits,
  input  logic [8:0]  in_amount,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [15:0] out_key_half,
  output logic [15:0] out_value_half,
  output logic [8:0]  out_fill_length,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hkv_pkg::*;

  logic [2:0] layers_r;
  logic [8:0] positions_r;
  logic [6:0] elements_r;
  cmd_t       f_cmd, q_head;
  logic       q_full, q_nonempty, q_pop, init_busy, push;

  assign pready   = 1'b1;
  assign in_stall = q_full || init_busy;
  assign push     = in_valid && !in_stall;

  always_comb begin
    case (paddr[3:2])
      REG_LAYERS:    prdata = {29'd0, layers_r};
      REG_POSITIONS: prdata = {23'd0, positions_r};
      REG_ELEMENTS:  prdata = {25'd0, elements_r};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layers_r    <= 3'(MAX_LAYERS);
      positions_r <= 9'(MAX_POSITIONS);
      elements_r  <= 7'(MAX_ELEMENTS);
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_LAYERS:    layers_r    <= pwdata[2:0];
        REG_POSITIONS: positions_r <= pwdata[8:0];
        REG_ELEMENTS:  elements_r  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  hkv_front #(
    .MAX_LAYERS(MAX_LAYERS), .MAX_POSITIONS(MAX_POSITIONS), .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_front (
    .kind(in_kind), .layer(in_layer), .position(in_position), .element(in_element),
    .key_bits(in_key_bits), .value_bits(in_value_bits), .amount(in_amount),
    .layers_used(layers_r), .positions_used(positions_r), .elements_used(elements_r),
    .cmd(f_cmd)
  );

  hkv_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_cmd(f_cmd), .full(q_full),
    .pop(q_pop), .nonempty(q_nonempty), .head(q_head)
  );

  hkv_back #(
    .MAX_LAYERS(MAX_LAYERS), .MAX_POSITIONS(MAX_POSITIONS), .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_nonempty(q_nonempty), .q_head(q_head), .q_pop(q_pop),
    .init_busy(init_busy), .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_key_half(out_key_half),
    .out_value_half(out_value_half), .out_fill_length(out_fill_length)
  );

endmodule

/* design/hkv_front.sv */
// hkv_front: converts float32 key and value to float16 and classifies each item.
// Depends on hkv_pkg.
`timescale 1ns / 1ps
module hkv_front #(
  parameter int MAX_LAYERS    = hkv_pkg::DEF_MAX_LAYERS,
  parameter int MAX_POSITIONS = hkv_pkg::DEF_MAX_POSITIONS,
  parameter int MAX_ELEMENTS  = hkv_pkg::DEF_MAX_ELEMENTS
) (
  input  logic [2:0]    kind,
  input  logic [1:0]    layer,
  input  logic [7:0]    position,
  input  logic [5:0]    element,
  input  logic [31:0]   key_bits,
  input  logic [31:0]   value_bits,
  input  logic [8:0]    amount,
  input  logic [2:0]    layers_used,
  input  logic [8:0]    positions_used,
  input  logic [6:0]    elements_used,
  output hkv_pkg::cmd_t cmd
);
  import hkv_pkg::*;

  function automatic logic [31:0] clamp(input logic [31:0] v, input int hi);
    logic [31:0] r;
    if (v == 32'd0) r = 32'd1;
    else if (v > 32'(hi)) r = 32'(hi);
    else r = v;
    return r;
  endfunction

  function automatic logic [15:0] to_half(input logic [31:0] b);
    logic        s;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [23:0] full;
    logic [23:0] hm;
    logic [4:0]  sh;
    logic [4:0]  he;
    logic [10:0] hm11;
    logic        rb;
    logic        lowb;
    logic [15:0] r;
    s    = b[31];
    ex   = b[30:23];
    man  = b[22:0];
    full = {1'b1, man};
    hm   = '0;
    sh   = '0;
    he   = '0;
    hm11 = '0;
    rb   = 1'b0;
    lowb = 1'b0;
    if (ex == 8'hFF) begin
      r = {s, 5'h1F, man[22:13]};
    end else if (ex >= 8'd143) begin
      r = {s, 15'h7C00};
    end else if (ex <= 8'd112) begin
      if (ex < 8'd102) begin
        r = {s, 15'd0};
      end else begin
        sh   = 5'(8'd126 - ex);
        hm   = full >> sh;
        rb   = full[sh - 5'd1];
        lowb = |(full & ((24'd1 << (sh - 5'd1)) - 24'd1));
        if (rb && (hm[0] || lowb)) hm = hm + 24'd1;
        r = {s, hm[14:0]};
      end
    end else begin
      he   = 5'(ex - 8'd112);
      hm11 = {1'b0, man[22:13]};
      rb   = man[12];
      lowb = |man[11:0];
      if (rb && (lowb || hm11[0])) hm11 = hm11 + 11'd1;
      if (hm11[10]) begin
        if (he == 5'd30) r = {s, 15'h7C00};
        else r = {s, he + 5'd1, 10'd0};
      end else begin
        r = {s, he, hm11[9:0]};
      end
    end
    return r;
  endfunction

  logic [31:0] nl, np, ne;
  logic        bad;

  assign nl  = clamp({29'd0, layers_used}, MAX_LAYERS);
  assign np  = clamp({23'd0, positions_used}, MAX_POSITIONS);
  assign ne  = clamp({25'd0, elements_used}, MAX_ELEMENTS);
  assign bad = ({30'd0, layer} >= nl) || ({24'd0, position} >= np) ||
               ({26'd0, element} >= ne);

  always_comb begin
    cmd.layer      = layer;
    cmd.position   = position;
    cmd.element    = element;
    cmd.key_half   = to_half(key_bits);
    cmd.value_half = to_half(value_bits);
    cmd.amount     = amount;
    case (kind)
      KIND_WRITE:    cmd.op = bad ? OP_REJECT : OP_WRITE;
      KIND_READ:     cmd.op = bad ? OP_REJECT : OP_READ;
      KIND_SHIFT:    cmd.op = OP_SHIFT;
      KIND_TRUNCATE: cmd.op = OP_TRUNC;
      KIND_RESET:    cmd.op = OP_CLEAR;
      default:       cmd.op = OP_NOP;
    endcase
  end

endmodule

/* design/hkv_queue.sv */
// hkv_queue: two-entry command queue between front and back.
// Depends on hkv_pkg.
`timescale 1ns / 1ps
module hkv_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hkv_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          nonempty,
  output hkv_pkg::cmd_t head
);
  import hkv_pkg::*;

  cmd_t       ent_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign nonempty = (cnt_r != 2'd0);
  assign head     = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_cmd;
  end

endmodule

/* design/hkv_back.sv */
// hkv_back: executes commands on the key/value memory, walks it for shift,
// truncate and clear, and holds the result register. Depends on hkv_pkg.
`timescale 1ns / 1ps
module hkv_back #(
  parameter int MAX_LAYERS    = hkv_pkg::DEF_MAX_LAYERS,
  parameter int MAX_POSITIONS = hkv_pkg::DEF_MAX_POSITIONS,
  parameter int MAX_ELEMENTS  = hkv_pkg::DEF_MAX_ELEMENTS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_nonempty,
  input  hkv_pkg::cmd_t q_head,
  output logic          q_pop,
  output logic          init_busy,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_status,
  output logic [15:0]   out_key_half,
  output logic [15:0]   out_value_half,
  output logic [8:0]    out_fill_length
);
  import hkv_pkg::*;

  localparam int POS_SPAN   = MAX_ELEMENTS;
  localparam int LAYER_SPAN = MAX_POSITIONS * MAX_ELEMENTS;
  localparam int DEPTH      = MAX_LAYERS * LAYER_SPAN;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PC_W       = $clog2(MAX_POSITIONS + 1);
  localparam int EC_W       = $clog2(MAX_ELEMENTS + 1);
  localparam int CW         = (PC_W > 9) ? PC_W : 9;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RD    = 5'b00010,
    S_SWEEP = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [8:0]         seq_r, seq_nxt;
  logic               init_r, init_nxt;
  logic [ADDR_W-1:0]  sa_r, sa_nxt, off_r, off_nxt;
  logic [PC_W-1:0]    sp_r, sp_nxt;
  logic [EC_W-1:0]    se_r, se_nxt;
  logic [8:0]         keep_r, keep_nxt;
  logic               shift_r, shift_nxt;
  logic               b_valid_r, b_valid_nxt, b_copy_r, b_copy_nxt;
  logic [ADDR_W-1:0]  b_addr_r, b_addr_nxt;
  logic               ov_r, ov_nxt, os_r, os_nxt;
  logic [15:0]        ok_r, ok_nxt, ovh_r, ovh_nxt;
  logic [8:0]         of_r, of_nxt;

  logic [31:0]        mem [DEPTH];
  logic [31:0]        rdata_r;
  logic               we, re;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [31:0]        wdata;

  logic               can_load, below, cp;
  logic [ADDR_W-1:0]  idx;
  logic [8:0]         pos1;

  assign can_load  = !ov_r || !out_stall;
  assign idx       = ADDR_W'(int'(q_head.layer) * LAYER_SPAN +
                             int'(q_head.position) * POS_SPAN + int'(q_head.element));
  assign pos1      = {1'b0, q_head.position} + 9'd1;
  assign below     = CW'(sp_r) < CW'(keep_r);
  assign cp        = shift_r && below;
  assign init_busy = init_r;

  assign out_valid       = ov_r;
  assign out_status      = os_r;
  assign out_key_half    = ok_r;
  assign out_value_half  = ovh_r;
  assign out_fill_length = of_r;

  always_comb begin
    state_nxt   = state_r;
    seq_nxt     = seq_r;
    init_nxt    = init_r;
    sa_nxt      = sa_r;
    sp_nxt      = sp_r;
    se_nxt      = se_r;
    off_nxt     = off_r;
    keep_nxt    = keep_r;
    shift_nxt   = shift_r;
    b_valid_nxt = 1'b0;
    b_copy_nxt  = cp;
    b_addr_nxt  = sa_r;
    ov_nxt      = ov_r && out_stall;
    os_nxt      = os_r;
    ok_nxt      = ok_r;
    ovh_nxt     = ovh_r;
    of_nxt      = of_r;
    q_pop       = 1'b0;
    we          = b_valid_r;
    waddr       = b_addr_r;
    wdata       = b_copy_r ? rdata_r : 32'd0;
    re          = 1'b0;
    raddr       = idx;

    case (state_r)
      S_IDLE: begin
        if (q_nonempty && can_load) begin
          q_pop  = 1'b1;
          os_nxt = 1'b0;
          ok_nxt = 16'd0;
          ovh_nxt = 16'd0;
          sa_nxt = '0;
          sp_nxt = '0;
          se_nxt = '0;
          case (q_head.op)
            OP_WRITE: begin
              we    = 1'b1;
              waddr = idx;
              wdata = {q_head.key_half, q_head.value_half};
              if (pos1 > seq_r) seq_nxt = pos1;
              ov_nxt = 1'b1;
              of_nxt = (pos1 > seq_r) ? pos1 : seq_r;
            end
            OP_READ: begin
              re        = 1'b1;
              state_nxt = S_RD;
            end
            OP_REJECT: begin
              ov_nxt = 1'b1;
              os_nxt = 1'b1;
              of_nxt = seq_r;
            end
            OP_SHIFT: begin
              if (q_head.amount == 9'd0) begin
                ov_nxt = 1'b1;
                of_nxt = seq_r;
              end else if (q_head.amount >= seq_r) begin
                keep_nxt  = 9'd0;
                shift_nxt = 1'b0;
                seq_nxt   = 9'd0;
                state_nxt = S_SWEEP;
              end else begin
                keep_nxt  = seq_r - q_head.amount;
                shift_nxt = 1'b1;
                off_nxt   = ADDR_W'(int'(q_head.amount) * POS_SPAN);
                seq_nxt   = seq_r - q_head.amount;
                state_nxt = S_SWEEP;
              end
            end
            OP_TRUNC: begin
              if ({1'b0, q_head.position} < seq_r) begin
                keep_nxt  = {1'b0, q_head.position};
                shift_nxt = 1'b0;
                seq_nxt   = {1'b0, q_head.position};
                state_nxt = S_SWEEP;
              end else begin
                ov_nxt = 1'b1;
                of_nxt = seq_r;
              end
            end
            OP_CLEAR: begin
              keep_nxt  = 9'd0;
              shift_nxt = 1'b0;
              seq_nxt   = 9'd0;
              state_nxt = S_SWEEP;
            end
            default: begin
              ov_nxt = 1'b1;
              of_nxt = seq_r;
            end
          endcase
        end
      end
      S_RD: begin
        if (can_load) begin
          ov_nxt    = 1'b1;
          os_nxt    = 1'b0;
          ok_nxt    = rdata_r[31:16];
          ovh_nxt   = rdata_r[15:0];
          of_nxt    = seq_r;
          state_nxt = S_IDLE;
        end
      end
      S_SWEEP: begin
        re          = cp;
        raddr       = sa_r + off_r;
        b_valid_nxt = cp || !below;
        sa_nxt      = sa_r + ADDR_W'(1);
        if (se_r == EC_W'(MAX_ELEMENTS - 1)) begin
          se_nxt = '0;
          sp_nxt = (sp_r == PC_W'(MAX_POSITIONS - 1)) ? '0 : sp_r + PC_W'(1);
        end else begin
          se_nxt = se_r + EC_W'(1);
        end
        if (sa_r == ADDR_W'(DEPTH - 1)) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        init_nxt  = 1'b0;
        state_nxt = init_r ? S_IDLE : S_DONE;
      end
      S_DONE: begin
        if (can_load) begin
          ov_nxt    = 1'b1;
          os_nxt    = 1'b0;
          ok_nxt    = 16'd0;
          ovh_nxt   = 16'd0;
          of_nxt    = seq_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_SWEEP;
      seq_r     <= 9'd0;
      init_r    <= 1'b1;
      sa_r      <= '0;
      sp_r      <= '0;
      se_r      <= '0;
      keep_r    <= 9'd0;
      shift_r   <= 1'b0;
      b_valid_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      seq_r     <= seq_nxt;
      init_r    <= init_nxt;
      sa_r      <= sa_nxt;
      sp_r      <= sp_nxt;
      se_r      <= se_nxt;
      keep_r    <= keep_nxt;
      shift_r   <= shift_nxt;
      b_valid_r <= b_valid_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r    <= off_nxt;
    b_copy_r <= b_copy_nxt;
    b_addr_r <= b_addr_nxt;
    os_r     <= os_nxt;
    ok_r     <= ok_nxt;
    ovh_r    <= ovh_nxt;
    of_r     <= of_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

endmodule

/* design/hkv_checker.sv */
// hkv_checker: port-level assertions for half_precision_kv_cache, bound to the top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
module hkv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_status,
  input logic [15:0] out_key_half,
  input logic [15:0] out_value_half,
  input logic [8:0]  out_fill_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_key_half) &&
      $stable(out_value_half) && $stable(out_fill_length) && $stable(out_status))
    else $error("stalled result transfer changed");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_key_half == 16'd0 && out_value_half == 16'd0)
    else $error("rejected item returned data");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken during clearing pass");

endmodule

bind half_precision_kv_cache hkv_checker u_hkv_checker (.*);
